FILE: rtl/sdd_pkg.sv
// ----------------------------------------------------------------------------
// sdd_pkg: shared constants and helpers for the Stucki dither unit
// Row geometry, fixed-point limits and the weighted error share function.
// ----------------------------------------------------------------------------
package sdd_pkg;

  localparam int unsigned MaxWidth = 2048;
  // Two slack entries on each side plus room for the row-end flush reads.
  localparam int unsigned RowDepth = MaxWidth + 8;
  localparam int unsigned AddrW    = $clog2(RowDepth);
  localparam int unsigned PosW     = $clog2(MaxWidth);
  localparam int unsigned CfgW     = 12;
  localparam int unsigned LenW     = (AddrW > CfgW) ? AddrW : CfgW;
  localparam int unsigned GrayW    = 8;
  localparam int unsigned ErrW     = 16;
  localparam int unsigned SumW     = 12;

  localparam logic [CfgW-1:0] WidthReset = 12'd1280;
  localparam logic [SumW-1:0] ClampHigh  = 12'd4080;
  localparam logic [SumW-1:0] Threshold  = 12'd2048;

  // x / 42 as (x * Recip) >> RecipShift, exact for x below 27635
  localparam int unsigned MagW       = 12;
  localparam int unsigned ProdW      = 15;
  localparam int unsigned RecipW     = 15;
  localparam int unsigned ScaledW    = ProdW + RecipW;
  localparam int unsigned RecipShift = 20;
  localparam logic [RecipW-1:0] Recip = 15'd24967;

  typedef logic signed [ErrW-1:0] err_t;

  // (err * 2^sh) / 42, truncated toward zero
  function automatic err_t share(input err_t err, input logic [1:0] sh);
    logic [MagW-1:0]    mag;
    logic [ProdW-1:0]   prod;
    logic [ScaledW-1:0] scaled;
    logic [ErrW-1:0]    quo;
    mag    = err[ErrW-1] ? MagW'(-err) : MagW'(err);
    prod   = ProdW'(mag) << sh;
    scaled = ScaledW'(prod) * ScaledW'(Recip);
    quo    = ErrW'(scaled >> RecipShift);
    return err[ErrW-1] ? -$signed(quo) : $signed(quo);
  endfunction

endpackage

FILE: rtl/sdd_if.sv
// ----------------------------------------------------------------------------
// sdd_if: valid/ready channels of the Stucki dither unit
// Pixel input, packed byte output and width configuration channels.
// ----------------------------------------------------------------------------
interface sdd_pix_if import sdd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [GrayW-1:0] gray_level;
  logic             image_start;

  modport source (output valid, gray_level, image_start, input ready);
  modport sink   (input valid, gray_level, image_start, output ready);
endinterface

interface sdd_byte_if ();
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       row_end;

  modport source (output valid, packed_byte, row_end, input ready);
  modport sink   (input valid, packed_byte, row_end, output ready);
endinterface

interface sdd_cfg_if import sdd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CfgW-1:0] image_width;

  modport source (output valid, image_width, input ready);
  modport sink   (input valid, image_width, output ready);
endinterface

FILE: rtl/sdd_ram.sv
// ----------------------------------------------------------------------------
// sdd_ram: generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sdd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2056
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/stucki_error_diffusion_dither_unit.sv
// ----------------------------------------------------------------------------
// stucki_error_diffusion_dither_unit: 8-bit gray to 1-bit Stucki dither
// Error rows live in one RAM; each entry holds the error for the next row
// and the partial error for the row after. A row is finalized one entry
// per pixel behind the read pointer.
// ----------------------------------------------------------------------------
//  channel  | dir | beat payload              | notes
//  cfg_i    | in  | image_width               | always ready, write when idle
//  pix_i    | in  | gray_level, image_start   | one pixel per beat, raster order
//  byte_o   | out | packed_byte, row_end      | MSB = leftmost pixel
//
// One pixel per cycle inside a row while the output is not stalled. At each
// row end, 4 flush steps write the trailing error entries through the RAM,
// then the write stage drains before the next row reads.
// Reset needs no clearing pass: per-row extent marks make unwritten
// entries read as zero. A stalled output beat holds the pipeline only when
// the pixel in the compute stage has a byte to deliver.
// ----------------------------------------------------------------------------
module stucki_error_diffusion_dither_unit import sdd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  sdd_cfg_if.sink    cfg_i,
  sdd_pix_if.sink    pix_i,
  sdd_byte_if.source byte_o
);

  typedef enum logic [2:0] {
    StRun   = 3'b001,
    StFlush = 3'b010,
    StDrain = 3'b100
  } state_e;

  typedef struct packed {
    logic             virt;   // row-end flush step, no pixel
    logic             vlast;
    logic             start;
    logic             fresh;  // first pixel of a row
    logic             last;
    logic             emit;
    logic [GrayW-1:0] gray;
    logic [AddrW-1:0] x;
  } item_t;

  // ---------------- configuration ----------------
  logic [CfgW-1:0] width_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthReset;
    end else if (cfg_i.valid) begin
      width_q <= cfg_i.image_width;
    end
  end

  // ---------------- control state ----------------
  state_e           state_q, state_d;
  logic [PosW-1:0]  pos_q;
  logic [AddrW-1:0] xl_q;
  logic [1:0]       cnt_q;
  logic             s1_valid_q;
  item_t            s1_q;
  logic             wr_valid_q;
  logic [AddrW-1:0] wr_addr_q;
  logic [2*ErrW-1:0] wr_data_q;
  logic             ev1_q, ev2_q;
  logic [AddrW-1:0] e1_q, e2_q;
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             out_row_end_q;

  // error windows
  err_t       nwin_q [4];
  err_t       awin_q [4];
  err_t       cc_q, cn_q;
  logic [7:0] acc_q;

  // ---------------- accept stage ----------------
  logic [LenW-1:0] cfg_len, w_eff, x_raw, x_sat;
  logic            px_last;
  item_t           pix_item, virt_item, load_item;
  logic            adv1, s1_free, in_acc, v_load, load;
  logic [AddrW-1:0] raddr;

  always_comb begin
    cfg_len = LenW'(width_q);
    if (cfg_len == '0) begin
      w_eff = LenW'(1);
    end else if (cfg_len > LenW'(MaxWidth)) begin
      w_eff = LenW'(MaxWidth);
    end else begin
      w_eff = cfg_len;
    end
    x_raw   = pix_i.image_start ? '0 : LenW'(pos_q);
    x_sat   = (x_raw >= w_eff) ? (w_eff - LenW'(1)) : x_raw;
    px_last = (x_sat == (w_eff - LenW'(1)));

    pix_item       = '0;
    pix_item.start = pix_i.image_start;
    pix_item.fresh = pix_i.image_start || (x_sat == '0);
    pix_item.last  = px_last;
    pix_item.emit  = px_last || (x_sat[2:0] == 3'd7);
    pix_item.gray  = pix_i.gray_level;
    pix_item.x     = AddrW'(x_sat);

    virt_item       = '0;
    virt_item.virt  = 1'b1;
    virt_item.vlast = (cnt_q == 2'd3);
    virt_item.x     = xl_q + AddrW'(cnt_q) + AddrW'(1);
  end

  assign adv1    = s1_valid_q && !(s1_q.emit && !s1_q.virt && out_valid_q && !byte_o.ready);
  assign s1_free = !s1_valid_q || adv1;
  assign pix_i.ready = (state_q == StRun) && s1_free;
  assign in_acc  = pix_i.valid && pix_i.ready;
  assign v_load  = (state_q == StFlush) && s1_free;
  assign load    = in_acc || v_load;
  assign load_item = in_acc ? pix_item : virt_item;
  assign raddr   = load_item.x + AddrW'(2);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StRun: begin
        if (in_acc && px_last) begin
          state_d = StFlush;
        end
      end
      StFlush: begin
        if (v_load && (cnt_q == 2'd3)) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (!s1_valid_q && !wr_valid_q) begin
          state_d = StRun;
        end
      end
      default: state_d = StRun;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StRun;
      pos_q      <= '0;
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      s1_valid_q <= load || (s1_valid_q && !adv1);
      if (in_acc) begin
        pos_q <= px_last ? '0 : PosW'(x_sat + LenW'(1));
        cnt_q <= '0;
      end else if (v_load) begin
        cnt_q <= cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_q <= load_item;
    end
    if (in_acc && px_last) begin
      xl_q <= AddrW'(x_sat);
    end
  end

  // ---------------- error row RAM ----------------
  logic [2*ErrW-1:0] rd_data;

  sdd_ram #(
    .Width (2 * ErrW),
    .Depth (RowDepth)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (wr_valid_q),
    .waddr_i (wr_addr_q),
    .wdata_i (wr_data_q),
    .re_i    (load),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  // ---------------- compute stage ----------------
  logic [AddrW-1:0] ridx;
  logic             in1, in2, white;
  err_t             f0, f1, cur, carry, sum, err;
  err_t             cc_b, cn_b;
  err_t             nb [4];
  err_t             ab [4];
  err_t             nn [5];
  err_t             an [5];
  err_t             sh1, sh2, sh4, sh8;
  logic [SumW-1:0]  s_cl;
  logic [7:0]       acc_b, acc_new;

  always_comb begin
    f0   = err_t'(rd_data[2*ErrW-1:ErrW]);
    f1   = err_t'(rd_data[ErrW-1:0]);
    ridx = s1_q.x + AddrW'(2);
    // entry written last row holds {this row, next row}; two rows back
    // only its second half still counts
    in1   = !s1_q.start && ev1_q && (ridx <= e1_q);
    in2   = !s1_q.start && ev2_q && (ridx <= e2_q);
    cur   = in1 ? f0 : (in2 ? f1 : '0);
    carry = in1 ? f1 : '0;

    for (int k = 0; k < 4; k++) begin
      nb[k] = s1_q.fresh ? '0 : nwin_q[k];
      ab[k] = s1_q.fresh ? '0 : awin_q[k];
    end
    cc_b  = s1_q.fresh ? '0 : cc_q;
    cn_b  = s1_q.fresh ? '0 : cn_q;
    acc_b = s1_q.fresh ? '0 : acc_q;

    sum = err_t'({s1_q.gray, 4'b0000}) + cur + cc_b;
    if (sum < 0) begin
      s_cl = '0;
    end else if (sum > err_t'(ClampHigh)) begin
      s_cl = ClampHigh;
    end else begin
      s_cl = sum[SumW-1:0];
    end
    white = !s1_q.virt && (s_cl >= Threshold);
    err   = s1_q.virt ? '0 : (err_t'(s_cl) - (white ? err_t'(ClampHigh) : '0));

    sh1 = share(err, 2'd0);
    sh2 = share(err, 2'd1);
    sh4 = share(err, 2'd2);
    sh8 = share(err, 2'd3);

    nn[0] = nb[0] + sh2;
    nn[1] = nb[1] + sh4;
    nn[2] = nb[2] + sh8 + carry;
    nn[3] = nb[3] + sh4;
    nn[4] = sh2;
    an[0] = ab[0] + sh1;
    an[1] = ab[1] + sh2;
    an[2] = ab[2] + sh4;
    an[3] = ab[3] + sh2;
    an[4] = sh1;

    acc_new = acc_b | (white ? (8'h80 >> s1_q.x[2:0]) : 8'h00);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ev1_q       <= 1'b0;
      ev2_q       <= 1'b0;
    end else begin
      wr_valid_q  <= adv1;
      out_valid_q <= (adv1 && !s1_q.virt && s1_q.emit) || (out_valid_q && !byte_o.ready);
      if (adv1 && s1_q.start) begin
        ev1_q <= 1'b0;
        ev2_q <= 1'b0;
      end else if (adv1 && s1_q.vlast) begin
        ev1_q <= 1'b1;
        ev2_q <= ev1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      wr_addr_q <= s1_q.x;
      wr_data_q <= {nn[0], an[0]};
      for (int k = 0; k < 4; k++) begin
        nwin_q[k] <= nn[k+1];
        awin_q[k] <= an[k+1];
      end
      if (s1_q.vlast) begin
        e1_q <= s1_q.x;
        e2_q <= e1_q;
      end
      if (!s1_q.virt) begin
        cc_q  <= cn_b + sh8;
        cn_q  <= sh4;
        acc_q <= s1_q.emit ? 8'h00 : acc_new;
        if (s1_q.emit) begin
          out_byte_q    <= acc_new;
          out_row_end_q <= s1_q.last;
        end
      end
    end
  end

  assign byte_o.valid       = out_valid_q;
  assign byte_o.packed_byte = out_byte_q;
  assign byte_o.row_end     = out_row_end_q;

endmodule
